FILE: design/ida_pkg.sv
`timescale 1ns / 1ps
// Package for the indexed insert/delete array core.
// Holds the transaction structs, operation and status codes and the cell control struct.
// No dependencies.
package ida_pkg;

   localparam int POS_W   = 6;
   localparam int COUNT_W = 7;
   localparam int WORD_W  = 32;

   localparam logic [2:0] OP_PUSH   = 3'd0;
   localparam logic [2:0] OP_POP    = 3'd1;
   localparam logic [2:0] OP_INSERT = 3'd2;
   localparam logic [2:0] OP_DELETE = 3'd3;
   localparam logic [2:0] OP_READ   = 3'd4;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_BAD_INDEX = 2'd1;
   localparam logic [1:0] ST_EMPTY     = 2'd2;
   localparam logic [1:0] ST_FULL      = 2'd3;

   typedef struct packed {
      logic [2:0]               operation;
      logic [POS_W-1:0]         position;
      logic signed [WORD_W-1:0] word_in;
   } req_type;

   typedef struct packed {
      logic signed [WORD_W-1:0] word_out;
      logic [COUNT_W-1:0]       count;
      logic                     is_empty;
      logic [1:0]               status;
   } rsp_type;

   typedef struct packed {
      logic ins;
      logic del;
   } cell_ctl_type;

endpackage

FILE: design/ida_cell.sv
`timescale 1ns / 1ps
// One storage cell of the array chain.
// Loads the new word, its left neighbor or its right neighbor; depends on ida_pkg.
module ida_cell import ida_pkg::*; #(
   parameter int DATA_WIDTH = 32,
   parameter int POS_WIDTH  = 7,
   parameter int INDEX      = 0
) (
   input  logic                  clock,
   input  cell_ctl_type          ctl,
   input  logic [POS_WIDTH-1:0]  pos,
   input  logic [DATA_WIDTH-1:0] word,
   input  logic [DATA_WIDTH-1:0] left_data,
   input  logic [DATA_WIDTH-1:0] right_data,
   output logic [DATA_WIDTH-1:0] data_out
);

   localparam logic [POS_WIDTH-1:0] MY_INDEX = POS_WIDTH'(INDEX);

   logic [DATA_WIDTH-1:0] data_ff;
   logic [DATA_WIDTH-1:0] data_in;

   always_comb begin
      data_in = data_ff;
      if (ctl.ins) begin
         if (MY_INDEX == pos) begin
            data_in = word;
         end else if (MY_INDEX > pos) begin
            data_in = left_data;
         end
      end else if (ctl.del && (MY_INDEX >= pos)) begin
         data_in = right_data;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data_out = data_ff;

endmodule

FILE: design/indexed_insert_delete_array_core.sv
`timescale 1ns / 1ps
// Indexed insert/delete array core: a row of cells that shift together on insert and delete.
// The result of a transaction is registered and presented in the cycle after it is accepted.
// Throughput: one transaction per cycle unless rsp_stall holds a result; no shift on pop or read.
// Reset clears the element count and the result valid; cell contents stay undefined until written.
// Depends on ida_pkg and ida_cell.
module indexed_insert_delete_array_core import ida_pkg::*; #(
   parameter int DEPTH      = 64,
   parameter int DATA_WIDTH = 32
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   localparam int FILL_W = $clog2(DEPTH + 1);
   localparam int EXT_W  = (FILL_W > COUNT_W) ? FILL_W : COUNT_W;
   localparam logic [FILL_W-1:0] FULL_FILL = FILL_W'(DEPTH);

   logic [FILL_W-1:0]     fill_ff;
   logic [FILL_W-1:0]     fill_in;
   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   rsp_type               rsp_data_ff;
   rsp_type               rsp_data_in;

   logic                  accept;
   logic [EXT_W-1:0]      pos_ext;
   logic [EXT_W-1:0]      fill_ext;
   logic [EXT_W-1:0]      cell_pos;
   logic [63:0]           word_in_ext;
   logic [DATA_WIDTH-1:0] word_store;
   logic [DATA_WIDTH-1:0] read_sel;
   logic [63:0]           read_ext;
   logic [EXT_W-1:0]      fill_next_ext;
   cell_ctl_type          op_ctl;
   cell_ctl_type          cell_ctl;
   logic                  use_fill_pos;
   logic [1:0]            status;
   logic                  read_ok;
   logic [DATA_WIDTH-1:0] cell_data [DEPTH];

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;

   assign pos_ext     = EXT_W'(req_data.position);
   assign fill_ext    = EXT_W'(fill_ff);
   assign word_in_ext = 64'(req_data.word_in);
   assign word_store  = word_in_ext[DATA_WIDTH-1:0];

   always_comb begin
      op_ctl       = '0;
      use_fill_pos = 1'b0;
      status       = ST_OK;
      read_ok      = 1'b0;
      fill_in      = fill_ff;
      case (req_data.operation)
         OP_PUSH: begin
            if (fill_ff == FULL_FILL) begin
               status = ST_FULL;
            end else begin
               op_ctl.ins   = 1'b1;
               use_fill_pos = 1'b1;
               fill_in      = fill_ff + 1'b1;
            end
         end
         OP_POP: begin
            if (fill_ff == '0) begin
               status = ST_EMPTY;
            end else begin
               fill_in = fill_ff - 1'b1;
            end
         end
         OP_INSERT: begin
            if (pos_ext >= fill_ext) begin
               status = ST_BAD_INDEX;
            end else if (fill_ff == FULL_FILL) begin
               status = ST_FULL;
            end else begin
               op_ctl.ins = 1'b1;
               fill_in    = fill_ff + 1'b1;
            end
         end
         OP_DELETE: begin
            if (pos_ext >= fill_ext) begin
               status = ST_BAD_INDEX;
            end else begin
               op_ctl.del = 1'b1;
               fill_in    = fill_ff - 1'b1;
            end
         end
         OP_READ: begin
            if (pos_ext >= fill_ext) begin
               status = ST_BAD_INDEX;
            end else begin
               read_ok = 1'b1;
            end
         end
         default: begin
            status = ST_OK;
         end
      endcase
   end

   assign cell_ctl.ins = accept && op_ctl.ins;
   assign cell_ctl.del = accept && op_ctl.del;
   assign cell_pos     = use_fill_pos ? fill_ext : pos_ext;

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic [DATA_WIDTH-1:0] left_data;
      logic [DATA_WIDTH-1:0] right_data;
      if (i == 0) begin : g_first
         assign left_data = cell_data[i];
      end else begin : g_mid_left
         assign left_data = cell_data[i-1];
      end
      if (i == DEPTH - 1) begin : g_last
         assign right_data = cell_data[i];
      end else begin : g_mid_right
         assign right_data = cell_data[i+1];
      end
      ida_cell #(
         .DATA_WIDTH(DATA_WIDTH),
         .POS_WIDTH (EXT_W),
         .INDEX     (i)
      ) u_cell (
         .clock     (clock),
         .ctl       (cell_ctl),
         .pos       (cell_pos),
         .word      (word_store),
         .left_data (left_data),
         .right_data(right_data),
         .data_out  (cell_data[i])
      );
   end

   always_comb begin
      read_sel = '0;
      for (int i = 0; i < DEPTH; i++) begin
         if (EXT_W'(i) == pos_ext) begin
            read_sel = read_sel | cell_data[i];
         end
      end
   end

   assign read_ext      = 64'(signed'(read_sel));
   assign fill_next_ext = EXT_W'(fill_in);

   always_comb begin
      rsp_data_in.word_out = read_ok ? read_ext[WORD_W-1:0] : '0;
      rsp_data_in.count    = fill_next_ext[COUNT_W-1:0];
      rsp_data_in.is_empty = (fill_in == '0);
      rsp_data_in.status   = status;
   end

   assign rsp_valid_in = accept || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            fill_ff <= fill_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

FILE: bench/testbench.sv
`timescale 1ns / 1ps
// Testbench for indexed_insert_delete_array_core: push, pop, insert, delete and read transactions
// with bursty input pacing and output back-pressure, each result checked against a predictor or row.
// Depends on ida_pkg and indexed_insert_delete_array_core; reads no files.
module testbench;
   import ida_pkg::*;

   localparam int DEPTH        = 64;
   localparam int DATA_WIDTH   = 32;
   localparam int RANDOM_ITEMS = 1500;
   localparam int HOLD_CYCLES  = 300;

   localparam logic [2:0] OP_SPARE_FIRST = 3'd5;
   localparam logic [2:0] OP_SPARE_LAST  = 3'd7;

   localparam logic signed [WORD_W-1:0] W_ZERO = 32'sd0;
   localparam logic signed [WORD_W-1:0] W_ONE  = 32'sd1;
   localparam logic signed [WORD_W-1:0] W_FIVE = 32'sd5;
   localparam logic signed [WORD_W-1:0] W_NEG1 = -32'sd1;
   localparam logic signed [WORD_W-1:0] W_MAX  = 32'sh7FFF_FFFF;
   localparam logic signed [WORD_W-1:0] W_MIN  = 32'sh8000_0000;

   typedef enum int {MODE_FILL, MODE_DRAIN, MODE_MIX} mode_type;

   typedef struct packed {
      logic [2:0]               op;
      logic [POS_W-1:0]         pos;
      logic signed [WORD_W-1:0] word;
      logic                     known;
      logic signed [WORD_W-1:0] wout;
      logic [COUNT_W-1:0]       cnt;
      logic                     empty_flag;
      logic [1:0]               st;
   } row_type;

   localparam int DIRECTED_COUNT = 24;

   // Rows whose known flag is low are checked against the predictor.
   localparam row_type DIRECTED_ROWS [DIRECTED_COUNT] = '{
      '{OP_POP,         6'd0,  W_ZERO, 1'b1, W_ZERO, 7'd0, 1'b1, ST_EMPTY},
      '{OP_READ,        6'd0,  W_ZERO, 1'b1, W_ZERO, 7'd0, 1'b1, ST_BAD_INDEX},
      '{OP_DELETE,      6'd0,  W_ZERO, 1'b1, W_ZERO, 7'd0, 1'b1, ST_BAD_INDEX},
      '{OP_INSERT,      6'd0,  W_FIVE, 1'b1, W_ZERO, 7'd0, 1'b1, ST_BAD_INDEX},
      '{OP_SPARE_FIRST, 6'd63, W_NEG1, 1'b1, W_ZERO, 7'd0, 1'b1, ST_OK},
      '{OP_PUSH,        6'd0,  W_MAX,  1'b1, W_ZERO, 7'd1, 1'b0, ST_OK},
      '{OP_PUSH,        6'd63, W_MIN,  1'b1, W_ZERO, 7'd2, 1'b0, ST_OK},
      '{OP_READ,        6'd0,  W_ZERO, 1'b1, W_MAX,  7'd2, 1'b0, ST_OK},
      '{OP_READ,        6'd1,  W_ZERO, 1'b1, W_MIN,  7'd2, 1'b0, ST_OK},
      '{OP_READ,        6'd2,  W_ZERO, 1'b1, W_ZERO, 7'd2, 1'b0, ST_BAD_INDEX},
      '{OP_INSERT,      6'd0,  W_NEG1, 1'b1, W_ZERO, 7'd3, 1'b0, ST_OK},
      '{OP_INSERT,      6'd2,  W_ZERO, 1'b1, W_ZERO, 7'd4, 1'b0, ST_OK},
      '{OP_READ,        6'd63, W_ZERO, 1'b1, W_ZERO, 7'd4, 1'b0, ST_BAD_INDEX},
      '{OP_INSERT,      6'd4,  W_ONE,  1'b1, W_ZERO, 7'd4, 1'b0, ST_BAD_INDEX},
      '{OP_DELETE,      6'd4,  W_ZERO, 1'b1, W_ZERO, 7'd4, 1'b0, ST_BAD_INDEX},
      '{OP_READ,        6'd2,  W_ZERO, 1'b0, W_ZERO, 7'd0, 1'b0, ST_OK},
      '{OP_DELETE,      6'd1,  W_ZERO, 1'b0, W_ZERO, 7'd0, 1'b0, ST_OK},
      '{OP_READ,        6'd1,  W_ZERO, 1'b0, W_ZERO, 7'd0, 1'b0, ST_OK},
      '{OP_SPARE_LAST,  6'd0,  W_ZERO, 1'b1, W_ZERO, 7'd3, 1'b0, ST_OK},
      '{OP_DELETE,      6'd2,  W_ZERO, 1'b0, W_ZERO, 7'd0, 1'b0, ST_OK},
      '{OP_POP,         6'd0,  W_ZERO, 1'b1, W_ZERO, 7'd1, 1'b0, ST_OK},
      '{OP_READ,        6'd0,  W_ZERO, 1'b0, W_ZERO, 7'd0, 1'b0, ST_OK},
      '{OP_POP,         6'd0,  W_ZERO, 1'b1, W_ZERO, 7'd0, 1'b1, ST_OK},
      '{OP_READ,        6'd0,  W_ZERO, 1'b1, W_ZERO, 7'd0, 1'b1, ST_BAD_INDEX}
   };

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   logic signed [WORD_W-1:0] array_words [DEPTH];
   int      array_fill = 0;
   rsp_type pending_rsp [$];
   bit      pinned_known = 1'b0;
   rsp_type pinned_rsp   = '0;

   int error_count     = 0;
   int checked_count   = 0;
   int full_count      = 0;
   int empty_count     = 0;
   int bad_index_count = 0;
   int peak_fill       = 0;
   int burst_left      = 0;
   int useful_sent     = 0;

   indexed_insert_delete_array_core #(
      .DEPTH      (DEPTH),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always #1 clock = ~clock;

   function automatic rsp_type apply_array_op(req_type r);
      rsp_type o;
      int      pos;
      int      i;
      o = '0;
      o.status = ST_OK;
      pos = int'(r.position);
      case (r.operation)
         OP_PUSH: begin
            if (array_fill >= DEPTH) begin
               o.status = ST_FULL;
            end else begin
               array_words[array_fill] = r.word_in;
               array_fill++;
            end
         end
         OP_POP: begin
            if (array_fill == 0) o.status = ST_EMPTY;
            else array_fill--;
         end
         OP_INSERT: begin
            if (pos >= array_fill) begin
               o.status = ST_BAD_INDEX;
            end else if (array_fill >= DEPTH) begin
               o.status = ST_FULL;
            end else begin
               for (i = array_fill; i > pos; i--) array_words[i] = array_words[i - 1];
               array_words[pos] = r.word_in;
               array_fill++;
            end
         end
         OP_DELETE: begin
            if (pos >= array_fill) begin
               o.status = ST_BAD_INDEX;
            end else begin
               for (i = pos; i + 1 < array_fill; i++) array_words[i] = array_words[i + 1];
               array_fill--;
            end
         end
         OP_READ: begin
            if (pos >= array_fill) o.status = ST_BAD_INDEX;
            else o.word_out = array_words[pos];
         end
         default: begin
         end
      endcase
      o.count = COUNT_W'(array_fill);
      o.is_empty = (array_fill == 0);
      if (array_fill > peak_fill) peak_fill = array_fill;
      return o;
   endfunction

   task automatic compare_rsp(input rsp_type want, input rsp_type got);
      if (got.word_out !== want.word_out) begin
         $error("word_out: expected %0d, actual %0d", want.word_out, got.word_out);
         error_count++;
      end
      if (got.count !== want.count) begin
         $error("count: expected %0d, actual %0d", want.count, got.count);
         error_count++;
      end
      if (got.is_empty !== want.is_empty) begin
         $error("is_empty: expected %0d, actual %0d", want.is_empty, got.is_empty);
         error_count++;
      end
      if (got.status !== want.status) begin
         $error("status: expected %0d, actual %0d", want.status, got.status);
         error_count++;
      end
      checked_count++;
      case (want.status)
         ST_FULL:      full_count++;
         ST_EMPTY:     empty_count++;
         ST_BAD_INDEX: bad_index_count++;
         default: begin
         end
      endcase
   endtask

   always @(posedge clock) begin : result_check
      rsp_type want;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            want = apply_array_op(req_data);
            if (pinned_known) want = pinned_rsp;
            pending_rsp.push_back(want);
         end
         if (rsp_valid && !rsp_stall) begin
            if (pending_rsp.size() == 0) begin
               $error("result transaction arrived with no expectation pending");
               error_count++;
            end else begin
               want = pending_rsp.pop_front();
               compare_rsp(want, rsp_data);
            end
         end
      end
   end

   function automatic logic signed [WORD_W-1:0] pick_word();
      case ($urandom_range(0, 9))
         0:       return 32'sh8000_0000;
         1:       return 32'sh7FFF_FFFF;
         2:       return 32'sh0000_0000;
         3:       return -32'sd1;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [POS_W-1:0] pick_position();
      int k;
      k = $urandom_range(0, 9);
      if (array_fill > 0 && k < 7) return POS_W'($urandom_range(0, array_fill - 1));
      if (k == 7) return POS_W'(array_fill > 0 ? array_fill - 1 : 0);
      if (k == 8) return POS_W'(array_fill);
      return POS_W'($urandom_range(0, DEPTH - 1));
   endfunction

   function automatic logic [2:0] pick_operation(mode_type mode);
      int roll;
      roll = $urandom_range(0, 99);
      case (mode)
         MODE_FILL: begin
            if (roll < 55) return OP_PUSH;
            if (roll < 80) return OP_INSERT;
            if (roll < 90) return OP_READ;
            if (roll < 95) return OP_POP;
            return OP_DELETE;
         end
         MODE_DRAIN: begin
            if (roll < 40) return OP_POP;
            if (roll < 80) return OP_DELETE;
            if (roll < 90) return OP_READ;
            if (roll < 95) return OP_PUSH;
            return OP_INSERT;
         end
         default: begin
            if (roll < 18) return OP_PUSH;
            if (roll < 36) return OP_POP;
            if (roll < 54) return OP_INSERT;
            if (roll < 72) return OP_DELETE;
            if (roll < 94) return OP_READ;
            return 3'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST));
         end
      endcase
   endfunction

   // Called right after a falling edge; holds the transaction until it is accepted.
   task automatic offer(input req_type item, input bit known, input rsp_type typed);
      req_valid    <= 1'b1;
      req_data     <= item;
      pinned_known <= known;
      pinned_rsp   <= typed;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic pace();
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         repeat (gap) @(negedge clock) req_valid <= 1'b0;
      end
      burst_left--;
      @(negedge clock);
   endtask

   task automatic drain();
      @(negedge clock) req_valid <= 1'b0;
      while (pending_rsp.size() != 0) @(negedge clock);
   endtask

   task automatic row(input row_type r);
      req_type item;
      rsp_type typed;
      item.operation = r.op;
      item.position  = r.pos;
      item.word_in   = r.word;
      typed.word_out = r.wout;
      typed.count    = r.cnt;
      typed.is_empty = r.empty_flag;
      typed.status   = r.st;
      pace();
      offer(item, r.known, typed);
   endtask

   task automatic send_item(input mode_type mode, input bit forced, input logic [2:0] op);
      req_type item;
      pace();
      item.operation = forced ? op : pick_operation(mode);
      item.position  = pick_position();
      item.word_in   = pick_word();
      offer(item, 1'b0, '0);
      if (item.operation <= OP_READ) useful_sent++;
   endtask

   initial begin : receiver
      int hold_point;
      int n;
      hold_point = 400;
      wait (!reset);
      forever begin
         if (checked_count >= hold_point) begin
            repeat (HOLD_CYCLES) @(negedge clock) rsp_stall <= 1'b1;
            hold_point += 700;
         end
         n = $urandom_range(10, 80);
         case ($urandom_range(0, 3))
            0: repeat (n) @(negedge clock) rsp_stall <= 1'b0;
            1: repeat (n) @(negedge clock) rsp_stall <= 1'($urandom_range(0, 1));
            2: repeat (n) @(negedge clock) rsp_stall <= ($urandom_range(0, 3) != 0);
            default: for (int i = 0; i < n; i++) @(negedge clock) rsp_stall <= (i % 3 == 2);
         endcase
      end
   end

   initial begin : stimulus
      mode_type mode;
      int       seg;
      int       guard;

      repeat (8) @(negedge clock);
      reset <= 1'b0;

      for (int k = 0; k < DIRECTED_COUNT; k++) begin
         row(DIRECTED_ROWS[k]);
      end
      drain();

      seg = 0;
      while (useful_sent < RANDOM_ITEMS) begin
         mode = (seg == 0) ? MODE_FILL : mode_type'($urandom_range(0, 2));
         seg++;
         guard = 0;
         case (mode)
            MODE_FILL: begin
               while (array_fill < DEPTH && guard < 600) begin
                  send_item(MODE_FILL, 1'b0, OP_PUSH);
                  guard++;
               end
               send_item(MODE_MIX, 1'b1, OP_PUSH);
               send_item(MODE_MIX, 1'b1, OP_INSERT);
               send_item(MODE_MIX, 1'b1, OP_READ);
            end
            MODE_DRAIN: begin
               while (array_fill > 0 && guard < 600) begin
                  send_item(MODE_DRAIN, 1'b0, OP_POP);
                  guard++;
               end
               send_item(MODE_MIX, 1'b1, OP_POP);
               send_item(MODE_MIX, 1'b1, OP_DELETE);
               send_item(MODE_MIX, 1'b1, OP_INSERT);
               send_item(MODE_MIX, 1'b1, OP_READ);
            end
            default: begin
               repeat ($urandom_range(20, 120)) send_item(MODE_MIX, 1'b0, OP_PUSH);
            end
         endcase
         if (seg % 5 == 0) drain();
      end

      drain();
      repeat (10) @(posedge clock);
      if (pending_rsp.size() != 0) begin
         $error("%0d expected results never arrived", pending_rsp.size());
         error_count++;
      end
      $display("testbench: %0d results checked, peak fill %0d of %0d", checked_count, peak_fill,
               DEPTH);
      $display("testbench: rejections seen: %0d full, %0d empty pop, %0d bad index",
               full_count, empty_count, bad_index_count);
      if (error_count == 0) begin
         $display("testbench: done, clean");
      end else begin
         $display("testbench: done, errors");
      end
      $finish;
   end

   initial begin : watchdog
      #400000;
      $display("testbench: done, errors");
      $finish;
   end

endmodule
